// ===== hw/rtl/bsb_pkg.sv =====
// package for the b-spline basis evaluator
// shared constants and types; no dependencies
package bsb_pkg;

    localparam int KNOT_DEPTH_DEF = 64;
    localparam int MAX_DEGREE_DEF = 5;
    localparam int FRAC_BITS_DEF  = 24;
    localparam int KNOT_W         = 32;
    localparam int VAL_W          = FRAC_BITS_DEF + 1;
    localparam int DEG_W          = 3;
    localparam int IDX_W          = 6;
    localparam logic [DEG_W-1:0] DEGREE_RESET = 3'd3;

    typedef enum logic [0:0] {
        OP_WRITE = 1'b0,
        OP_EVAL  = 1'b1
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_LOAD_WAIT,
        ST_INIT,
        ST_NODE_RD,
        ST_NODE_WAIT,
        ST_LEFT_DIV,
        ST_LEFT_MUL,
        ST_RIGHT_DIV,
        ST_RIGHT_MUL,
        ST_NODE_SUM,
        ST_RESULT
    } state_t;

endpackage

// ===== hw/rtl/bsb_ram.sv =====
// generic single-port-write, single-read ram with registered read
// no dependencies
module bsb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/bsb_div.sv =====
// restoring radix-2 divider: unsigned quotient of (num << frac) / den
// uses bsb_pkg
module bsb_div
    import bsb_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [KNOT_W:0]               num,
    input  logic [KNOT_W:0]               den,
    output logic                          busy,
    output logic                          done,
    output logic [KNOT_W+FRAC_BITS_DEF:0] quo
);

    localparam int NW = KNOT_W + 1 + FRAC_BITS_DEF;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0]   quo_reg, quo_next;
    logic [KNOT_W+1:0] rem_reg, rem_next;
    logic [KNOT_W:0] den_reg, den_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [KNOT_W+1:0] trial;
    logic [KNOT_W+1:0] shifted;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[KNOT_W:0], quo_reg[NW-1]};
        trial     = shifted - {1'b0, den_reg};
        if (start)
        begin
            quo_next  = {num, {FRAC_BITS_DEF{1'b0}}};
            rem_next  = '0;
            den_next  = den;
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[KNOT_W+1])
            begin
                rem_next = trial;
                quo_next = {quo_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = quo_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while busy");
    a_cnt_zero_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy_reg && !start) |=> !busy_reg)
        else $error("divider started without request");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done longer than one cycle");

endmodule

// ===== hw/rtl/bsb_seq.sv =====
// recurrence sequencer: loads knots into a local window, walks the
// cox-de boor triangle with a shared divider; uses bsb_pkg
module bsb_seq
    import bsb_pkg::*;
#(
    parameter int KNOT_DEPTH = KNOT_DEPTH_DEF,
    parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [DEG_W-1:0]              degree,
    input  logic [KNOT_W-1:0]             point,
    input  logic [IDX_W-1:0]              basis_index,
    output logic                          busy,
    output logic [$clog2(KNOT_DEPTH)-1:0] raddr,
    input  logic [KNOT_W-1:0]             rdata,
    output logic                          res_valid,
    input  logic                          res_ready,
    output logic [VAL_W-1:0]              res_value,
    output logic                          res_err
);

    localparam int AW  = $clog2(KNOT_DEPTH);
    localparam int WN  = MAX_DEGREE + 2;
    localparam int WAW = $clog2(WN + 1);
    localparam int QW  = KNOT_W + 1 + FRAC_BITS_DEF;
    localparam int SW  = KNOT_W + 1;
    localparam logic [VAL_W-1:0] ONE = VAL_W'(1) << FRAC_BITS_DEF;

    state_t st_reg, st_next;
    logic   div_start, div_busy, div_done;

    logic signed [KNOT_W-1:0] win_reg [WN];
    logic [VAL_W-1:0]         v_reg [WN];
    logic [WAW-1:0]           ld_reg, ld_next;
    logic [DEG_W-1:0]         deg_reg, deg_next;
    logic [DEG_W-1:0]         p_reg, p_next;
    logic [DEG_W-1:0]         j_reg, j_next;
    logic [DEG_W-1:0]         deg_clamp;
    logic signed [KNOT_W-1:0] x_reg;
    logic [AW:0]              base_reg;
    logic [VAL_W-1:0]         w_reg, left_reg, right_reg;
    logic [VAL_W-1:0]         res_value_reg;
    logic                     res_err_reg, res_valid_reg;
    logic [2*VAL_W-1:0]       prod;
    logic [VAL_W:0]           sum;
    logic [QW-1:0]            quo;
    logic                     neg_reg;
    logic [SW-1:0]            dnum, dden;
    logic signed [SW-1:0]     snum, sden;
    logic signed [KNOT_W-1:0] ta, tb, ti, tip1;
    logic                     zero_span, outside, win_we, v_we;
    logic [VAL_W-1:0]         v_wdata, wsat, factor;
    logic [WAW-1:0]           v_widx;
    logic                     range_bad;
    logic [QW-1:0]            q_sat;

    // window rows for the current node
    always_comb
    begin
        ti   = win_reg[j_reg];
        tip1 = win_reg[WAW'(j_reg) + WAW'(p_reg) + WAW'(1)];
        if (st_reg == ST_LEFT_DIV || st_reg == ST_NODE_RD)
        begin
            ta = ti;
            tb = win_reg[WAW'(j_reg) + WAW'(p_reg)];
        end
        else
        begin
            ta = win_reg[WAW'(j_reg) + WAW'(1)];
            tb = tip1;
        end
        snum = SW'(x_reg) - SW'(ta);
        sden = SW'(tb) - SW'(ta);
        dnum = snum[SW-1] ? SW'(-snum) : SW'(snum);
        dden = sden[SW-1] ? SW'(-sden) : SW'(sden);
        zero_span = (tb == ta);
        outside   = (x_reg < ti) || (x_reg >= tip1);
        deg_clamp = (degree > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : degree;
        range_bad = (32'(basis_index) + 32'(deg_clamp) + 32'd1) > 32'(KNOT_DEPTH - 1);
    end

    bsb_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (dnum),
        .den   (dden),
        .busy  (div_busy),
        .done  (div_done),
        .quo   (quo)
    );

    // saturate the signed quotient to [0, 1]
    always_comb
    begin
        q_sat = quo;
        if (neg_reg)
            wsat = (quo == '0) ? '0 : '0;
        else if (q_sat > QW'(ONE))
            wsat = ONE;
        else
            wsat = q_sat[VAL_W-1:0];
        factor = (st_reg == ST_LEFT_MUL) ? w_reg : ONE - w_reg;
        prod   = factor * ((st_reg == ST_LEFT_MUL) ? v_reg[j_reg]
                           : v_reg[WAW'(j_reg) + WAW'(1)]);
        sum    = {1'b0, left_reg} + {1'b0, right_reg};
    end

    // next state
    always_comb
    begin
        st_next  = st_reg;
        ld_next  = ld_reg;
        deg_next = deg_reg;
        p_next   = p_reg;
        j_next   = j_reg;
        if (start)
            deg_next = deg_clamp;
        unique case (st_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ld_next = '0;
                    st_next = range_bad ? ST_RESULT : ST_LOAD;
                end
            end
            ST_LOAD:
                st_next = ST_LOAD_WAIT;
            ST_LOAD_WAIT:
            begin
                ld_next = ld_reg + 1'b1;
                st_next = (ld_reg == WAW'(deg_reg) + WAW'(1)) ? ST_INIT : ST_LOAD;
            end
            ST_INIT:
            begin
                j_next = j_reg + 1'b1;
                if (j_reg == deg_reg)
                begin
                    j_next  = '0;
                    p_next  = DEG_W'(1);
                    st_next = (deg_reg == '0) ? ST_RESULT : ST_NODE_RD;
                end
            end
            ST_NODE_RD:
            begin
                if (outside)
                    st_next = ST_NODE_SUM;
                else if (zero_span)
                    st_next = ST_RIGHT_DIV;
                else
                    st_next = ST_LEFT_DIV;
            end
            ST_LEFT_DIV:
                if (div_done)
                    st_next = ST_LEFT_MUL;
            ST_LEFT_MUL:
                st_next = zero_span ? ST_NODE_SUM : ST_RIGHT_DIV;
            ST_RIGHT_DIV:
            begin
                if (!div_busy && !div_done && zero_span)
                    st_next = ST_NODE_SUM;
                else if (div_done)
                    st_next = ST_RIGHT_MUL;
            end
            ST_RIGHT_MUL:
                st_next = ST_NODE_SUM;
            ST_NODE_SUM:
            begin
                if (WAW'(j_reg) + WAW'(p_reg) == WAW'(deg_reg))
                begin
                    j_next = '0;
                    p_next = p_reg + 1'b1;
                    st_next = (p_reg == deg_reg) ? ST_RESULT : ST_NODE_RD;
                end
                else
                begin
                    j_next  = j_reg + 1'b1;
                    st_next = ST_NODE_RD;
                end
            end
            ST_RESULT:
                if (!res_valid_reg || res_ready)
                    st_next = ST_IDLE;
            default:
                st_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        div_start = 1'b0;
        win_we    = 1'b0;
        v_we      = 1'b0;
        v_widx    = WAW'(j_reg);
        v_wdata   = '0;
        raddr     = AW'(base_reg + (AW+1)'(ld_reg));
        unique case (st_reg)
            ST_LOAD_WAIT:
                win_we = 1'b1;
            ST_INIT:
            begin
                // degree-zero characteristic functions, one per cycle
                v_we    = 1'b1;
                v_wdata = (x_reg >= win_reg[j_reg] &&
                           x_reg < win_reg[WAW'(j_reg) + WAW'(1)]) ? ONE : '0;
            end
            ST_NODE_RD:
            begin
                if (outside)
                    v_we = 1'b1;
                else if (!zero_span)
                    div_start = 1'b1;
            end
            ST_LEFT_MUL:
                div_start = !zero_span;
            ST_RIGHT_DIV:
                div_start = !div_busy && !div_done && !zero_span;
            ST_NODE_SUM:
            begin
                v_we    = 1'b1;
                v_wdata = (sum > (VAL_W+1)'(ONE)) ? ONE : sum[VAL_W-1:0];
                if (outside)
                    v_wdata = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            ld_reg        <= '0;
            deg_reg       <= '0;
            p_reg         <= '0;
            j_reg         <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg  <= st_next;
            ld_reg  <= ld_next;
            deg_reg <= deg_next;
            p_reg   <= p_next;
            j_reg   <= j_next;
            if (st_reg == ST_RESULT && (!res_valid_reg || res_ready))
                res_valid_reg <= 1'b1;
            else if (res_ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == ST_IDLE && start)
        begin
            x_reg       <= point;
            base_reg    <= (AW+1)'(basis_index);
            res_err_reg <= range_bad;
        end
        if (win_we)
            win_reg[ld_reg] <= rdata;
        if (v_we)
            v_reg[v_widx] <= v_wdata;
        if (div_start)
            neg_reg <= snum[SW-1] != sden[SW-1];
        if (st_reg == ST_NODE_RD)
        begin
            left_reg  <= '0;
            right_reg <= '0;
        end
        if ((st_reg == ST_LEFT_DIV || st_reg == ST_RIGHT_DIV) && div_done)
            w_reg <= wsat;
        if (st_reg == ST_LEFT_MUL)
            left_reg <= prod[FRAC_BITS_DEF +: VAL_W];
        if (st_reg == ST_RIGHT_MUL)
            right_reg <= prod[FRAC_BITS_DEF +: VAL_W];
        if (st_reg == ST_RESULT && (!res_valid_reg || res_ready))
            res_value_reg <= (res_err_reg || deg_reg == DEG_W'(0) && 1'b0) ?
                             '0 : (res_err_reg ? '0 : v_reg[0]);
    end

    assign busy      = (st_reg != ST_IDLE);
    assign res_valid = res_valid_reg;
    assign res_value = res_value_reg;
    assign res_err   = res_err_reg;

    a_one_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");
    a_res_bound: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> res_value_reg <= ONE)
        else $error("basis value above one");
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_err_reg) |-> res_value_reg == '0)
        else $error("range error with nonzero value");
    a_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && st_reg != ST_IDLE) |-> 1'b0)
        else $error("start while busy");

endmodule

// ===== hw/rtl/bspline_basis_eval.sv =====
// b-spline basis evaluator, cox-de boor recurrence over a 64-entry knot ram
// knot writes are taken back to back; support past the table goes straight to the result state
// degree p: window load, degree-zero terms, then p(p+1)/2 nodes with up to two divides
// per inner node, then the result
// no new transfer until the result is taken; rst_n clears control, degree 3, ram kept
module bspline_basis_eval
    import bsb_pkg::*;
#(
    parameter int KNOT_DEPTH = KNOT_DEPTH_DEF,
    parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [DEG_W-1:0]        cfg_wdata,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    opcode,
    input  logic [IDX_W-1:0]        knot_slot,
    input  logic signed [KNOT_W-1:0] knot_value,
    input  logic signed [KNOT_W-1:0] point,
    input  logic [IDX_W-1:0]        basis_index,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [VAL_W-1:0]        basis_value,
    output logic                    range_error
);

    localparam int AW = $clog2(KNOT_DEPTH);

    logic [DEG_W-1:0] degree_reg;
    logic             seq_busy, accept, kwe;
    logic [AW-1:0]    raddr;
    logic [KNOT_W-1:0] rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            degree_reg <= DEGREE_RESET;
        else if (cfg_we)
            degree_reg <= cfg_wdata;
    end

    assign in_ready = !seq_busy && !out_valid;
    assign accept   = in_valid && in_ready;
    assign kwe      = accept && (opcode == OP_WRITE) &&
                      (32'(knot_slot) < 32'(KNOT_DEPTH));

    bsb_ram #(.WIDTH(KNOT_W), .DEPTH(KNOT_DEPTH)) u_ram (
        .clk   (clk),
        .we    (kwe),
        .waddr (AW'(knot_slot)),
        .wdata (knot_value),
        .raddr (raddr),
        .rdata (rdata)
    );

    bsb_seq #(
        .KNOT_DEPTH (KNOT_DEPTH),
        .MAX_DEGREE (MAX_DEGREE)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (accept && (opcode == OP_EVAL)),
        .degree      (degree_reg),
        .point       (point),
        .basis_index (basis_index),
        .busy        (seq_busy),
        .raddr       (raddr),
        .rdata       (rdata),
        .res_valid   (out_valid),
        .res_ready   (out_ready),
        .res_value   (basis_value),
        .res_err     (range_error)
    );

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        seq_busy |-> !in_ready)
        else $error("input taken while evaluating");
    a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && opcode == OP_WRITE) |=> !out_valid)
        else $error("knot write produced a result");
    a_out_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> basis_value <= (VAL_W'(1) << FRAC_BITS_DEF))
        else $error("output above one");

endmodule
